/* sv/pat_pkg.sv */
package pat_pkg;

    localparam logic [1:0] CMD_ANNOUNCE  = 2'd0;
    localparam logic [1:0] CMD_EXPIRE    = 2'd1;
    localparam logic [1:0] CMD_GET_PEERS = 2'd2;
    localparam logic [1:0] CMD_CLEAR     = 2'd3;

    localparam logic [2:0] ST_STORED      = 3'd0;
    localparam logic [2:0] ST_TARGET_FULL = 3'd1;
    localparam logic [2:0] ST_NODE_FULL   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN     = 3'd3;
    localparam logic [2:0] ST_PEER        = 3'd4;
    localparam logic [2:0] ST_DONE        = 3'd5;

    localparam int          RESULT_CAP     = 8;
    localparam logic [15:0] LIFETIME_RESET = 16'd1800;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] target_hi;
        logic [63:0] target_mid;
        logic [31:0] target_lo;
        logic [63:0] node_hi;
        logic [63:0] node_mid;
        logic [31:0] node_lo;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] port;
        logic [31:0] now;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_addr_hi;
        logic [63:0] out_addr_lo;
        logic [15:0] out_port;
        logic [2:0]  peer_index;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [63:0] node_hi;
        logic [63:0] node_mid;
        logic [31:0] node_lo;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] port;
        logic [31:0] deadline;
    } slot_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_SRCH,
        S_T_DONE,
        S_NT_WAIT,
        S_N_SRCH,
        S_N_DONE,
        S_X_T,
        S_X_NT,
        S_X_SRCH,
        S_X_END,
        S_G_ORD,
        S_G_SLOT,
        S_G_DATA,
        S_R_RD,
        S_R_WR,
        S_R_LAST,
        S_EMIT
    } state_t;

endpackage

/* sv/peer_announce_table.sv */
// Peer announce table.
// Requests enter on in_valid/in_ready with one in_t; results leave on
// out_valid/out_ready as out_t, one register deep. entry_lifetime is written
// on cfg_valid/cfg_ready (always ready); the user must write it only while
// the block is idle, as the block itself does not enforce this. One request
// is worked on at a time; in_ready is high only when idle.
// Announce and get_peers first sweep the target key memory over its single
// read port, one entry a cycle. Announce then walks the target's node list
// through the order and slot memories and gives one result. Get_peers reads
// the order and slot memories for each returned peer, then rotates the list.
// Expire visits every target, skipping free ones and compacting the list of
// each used one. Clear empties the table and gives one result.
// Reset empties the table at once through per-target valid bits; no
// memory clearing pass is needed. A stalled receiver holds the last result
// in the output register; the block stops only when it must load the next.
module peer_announce_table
    import pat_pkg::*;
    #(
        parameter int MAX_TARGETS  = 64,
        parameter int MAX_NODES    = 16,
        parameter int MAX_RETURNED = 8
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        cfg_valid,
        output logic        cfg_ready,
        input  logic [15:0] cfg_data,
        input  logic        in_valid,
        output logic        in_ready,
        input  in_t         in_data,
        output logic        out_valid,
        input  logic        out_ready,
        output out_t        out_data
    );

    localparam int SLOTS = MAX_TARGETS * MAX_NODES;
    localparam int TW    = MAX_TARGETS > 1 ? $clog2(MAX_TARGETS) : 1;
    localparam int IW    = $clog2(MAX_TARGETS + 1);
    localparam int NW    = MAX_NODES > 1 ? $clog2(MAX_NODES) : 1;
    localparam int NTW   = $clog2(MAX_NODES + 1);
    localparam int KW    = $clog2(MAX_NODES + 2);
    localparam int SW    = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int CAP   = MAX_RETURNED < RESULT_CAP ? MAX_RETURNED : RESULT_CAP;

    state_t             state_reg, state_next;
    in_t                req_reg, req_next;
    logic [15:0]        life_reg, life_next;
    logic [MAX_TARGETS-1:0] valid_reg, valid_next;
    logic [IW-1:0]      total_reg, total_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic               free_reg, free_next;
    logic [TW-1:0]      hit_t_reg, hit_t_next;
    logic [TW-1:0]      free_t_reg, free_t_next;
    logic [TW-1:0]      t_reg, t_next;
    logic [NTW-1:0]     n_reg, n_next;
    logic [NTW-1:0]     w_reg, w_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [NW-1:0]      fpipe_reg, fpipe_next;
    logic [NW-1:0]      found_f_reg, found_f_next;
    logic               found_reg, found_next;
    logic [NW-1:0]      head_reg, head_next;
    logic [MAX_NODES-1:0] used_reg, used_next;
    logic [2:0]         res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    logic [TW-1:0]  key_waddr, key_raddr;
    logic           key_we;
    logic [159:0]   key_rdata;
    logic [TW-1:0]  nt_waddr, nt_raddr;
    logic           nt_we;
    logic [NTW-1:0] nt_wdata, nt_rdata;
    logic [SW-1:0]  ord_waddr, ord_raddr;
    logic           ord_we;
    logic [NW-1:0]  ord_wdata, ord_rdata;
    logic [SW-1:0]  slot_waddr, slot_raddr;
    logic           slot_we, slot_re;
    slot_t          slot_wdata, slot_rdata;

    logic [TW-1:0]  ci;
    logic [NW-1:0]  free_f;
    logic [32:0]    dl_sum;
    logic [31:0]    dl_sat;
    logic           out_free;
    logic [KW-1:0]  n_ext;

    function automatic logic [SW-1:0] slot_addr(input logic [TW-1:0] t, input logic [NW-1:0] f);
        slot_addr = SW'(SW'(t) * SW'(MAX_NODES) + SW'(f));
    endfunction

    pat_ram #(.WIDTH(160), .DEPTH(MAX_TARGETS)) u_key (
        .clk(clk), .we(key_we), .waddr(key_waddr),
        .wdata({req_reg.target_hi, req_reg.target_mid, req_reg.target_lo}),
        .re(1'b1), .raddr(key_raddr), .rdata(key_rdata)
    );

    pat_ram #(.WIDTH(NTW), .DEPTH(MAX_TARGETS)) u_ntotal (
        .clk(clk), .we(nt_we), .waddr(nt_waddr), .wdata(nt_wdata),
        .re(1'b1), .raddr(nt_raddr), .rdata(nt_rdata)
    );

    pat_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_order (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .re(1'b1), .raddr(ord_raddr), .rdata(ord_rdata)
    );

    pat_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_slot (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign ci        = TW'(idx_reg - IW'(1));
    assign n_ext     = KW'(n_reg);

    assign dl_sum = {1'b0, req_reg.now} + {17'd0, life_reg};
    assign dl_sat = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];

    // lowest slot not referenced by the target's order list
    always_comb
    begin
        free_f = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_f = NW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            life_reg      <= LIFETIME_RESET;
            valid_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            life_reg      <= life_next;
            valid_reg     <= valid_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        free_reg     <= free_next;
        hit_t_reg    <= hit_t_next;
        free_t_reg   <= free_t_next;
        t_reg        <= t_next;
        n_reg        <= n_next;
        w_reg        <= w_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        fpipe_reg    <= fpipe_next;
        found_f_reg  <= found_f_next;
        found_reg    <= found_next;
        head_reg     <= head_next;
        used_reg     <= used_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        life_next      = cfg_valid ? cfg_data : life_reg;
        valid_next     = valid_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        hit_t_next     = hit_t_reg;
        free_t_next    = free_t_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        w_next         = w_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        fpipe_next     = fpipe_reg;
        found_f_next   = found_f_reg;
        found_next     = found_reg;
        head_next      = head_reg;
        used_next      = used_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        key_we     = 1'b0;
        key_waddr  = free_t_reg;
        key_raddr  = idx_reg[TW-1:0];
        nt_we      = 1'b0;
        nt_waddr   = t_reg;
        nt_wdata   = '0;
        nt_raddr   = (state_reg == S_X_T) ? idx_reg[TW-1:0] : hit_t_reg;
        ord_we     = 1'b0;
        ord_waddr  = slot_addr(t_reg, NW'(n_reg));
        ord_wdata  = free_f;
        ord_raddr  = slot_addr(t_reg, NW'(k_reg));
        slot_we    = 1'b0;
        slot_waddr = slot_addr(t_reg, found_reg ? found_f_reg : free_f);
        slot_wdata = '{node_hi: req_reg.node_hi, node_mid: req_reg.node_mid,
                       node_lo: req_reg.node_lo, addr_hi: req_reg.addr_hi,
                       addr_lo: req_reg.addr_lo, port: req_reg.port, deadline: dl_sat};
        slot_re    = 1'b0;
        slot_raddr = slot_addr(t_reg, ord_rdata);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = in_data;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    case (in_data.cmd)
                        CMD_ANNOUNCE, CMD_GET_PEERS:
                        begin
                            state_next = S_T_SRCH;
                        end
                        CMD_EXPIRE:
                        begin
                            state_next = S_X_T;
                        end
                        default:
                        begin
                            valid_next = '0;
                            total_next = '0;
                            res_next   = ST_DONE;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // read entry idx while checking entry idx-1
            S_T_SRCH:
            begin
                if (idx_reg != '0)
                begin
                    if (valid_reg[ci] && !hit_reg &&
                        key_rdata == {req_reg.target_hi, req_reg.target_mid, req_reg.target_lo})
                    begin
                        hit_next   = 1'b1;
                        hit_t_next = ci;
                    end
                    if (!valid_reg[ci] && !free_reg)
                    begin
                        free_next   = 1'b1;
                        free_t_next = ci;
                    end
                end
                if (idx_reg == IW'(MAX_TARGETS))
                begin
                    state_next = S_T_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            S_T_DONE:
            begin
                t_next    = hit_t_reg;
                used_next = '0;
                k_next    = '0;
                found_next = 1'b0;
                if (req_reg.cmd == CMD_ANNOUNCE)
                begin
                    if (total_reg >= IW'(MAX_TARGETS))
                    begin
                        res_next   = ST_TARGET_FULL;
                        state_next = S_EMIT;
                    end
                    else if (hit_reg)
                    begin
                        state_next = S_NT_WAIT;
                    end
                    else
                    begin
                        key_we                 = 1'b1;
                        nt_we                  = 1'b1;
                        nt_waddr               = free_t_reg;
                        nt_wdata               = '0;
                        valid_next[free_t_reg] = 1'b1;
                        total_next             = total_reg + IW'(1);
                        t_next                 = free_t_reg;
                        n_next                 = '0;
                        state_next             = S_N_SRCH;
                    end
                end
                else if (hit_reg)
                begin
                    state_next = S_NT_WAIT;
                end
                else
                begin
                    res_next   = ST_UNKNOWN;
                    state_next = S_EMIT;
                end
            end

            S_NT_WAIT:
            begin
                n_next = nt_rdata;
                if (req_reg.cmd == CMD_ANNOUNCE)
                begin
                    if (32'(nt_rdata) >= MAX_NODES)
                    begin
                        res_next   = ST_NODE_FULL;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_N_SRCH;
                    end
                end
                else if (nt_rdata == '0)
                begin
                    res_next   = ST_DONE;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next   = (32'(nt_rdata) > CAP) ? 4'(CAP) : 4'(nt_rdata);
                    state_next = S_G_ORD;
                end
            end

            // order read for k, slot read for k-1, id compare for k-2
            S_N_SRCH:
            begin
                if (k_reg >= KW'(1) && k_reg <= n_ext)
                begin
                    slot_re             = 1'b1;
                    used_next[ord_rdata] = 1'b1;
                    fpipe_next          = ord_rdata;
                end
                if (k_reg >= KW'(2) && !found_reg &&
                    slot_rdata.node_hi == req_reg.node_hi &&
                    slot_rdata.node_mid == req_reg.node_mid &&
                    slot_rdata.node_lo == req_reg.node_lo)
                begin
                    found_next   = 1'b1;
                    found_f_next = fpipe_reg;
                end
                if (k_reg == n_ext + KW'(1))
                begin
                    state_next = S_N_DONE;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end

            S_N_DONE:
            begin
                slot_we = 1'b1;
                if (!found_reg)
                begin
                    ord_we   = 1'b1;
                    nt_we    = 1'b1;
                    nt_wdata = n_reg + NTW'(1);
                end
                res_next   = ST_STORED;
                state_next = S_EMIT;
            end

            S_X_T:
            begin
                if (idx_reg == IW'(MAX_TARGETS))
                begin
                    res_next   = ST_DONE;
                    state_next = S_EMIT;
                end
                else if (valid_reg[idx_reg[TW-1:0]])
                begin
                    t_next     = idx_reg[TW-1:0];
                    state_next = S_X_NT;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            S_X_NT:
            begin
                n_next     = nt_rdata;
                k_next     = '0;
                w_next     = '0;
                state_next = S_X_SRCH;
            end

            // compacts the order list in place; writes trail the reads
            S_X_SRCH:
            begin
                if (k_reg >= KW'(1) && k_reg <= n_ext)
                begin
                    slot_re    = 1'b1;
                    fpipe_next = ord_rdata;
                end
                if (k_reg >= KW'(2) && !(req_reg.now > slot_rdata.deadline))
                begin
                    ord_we    = 1'b1;
                    ord_waddr = slot_addr(t_reg, NW'(w_reg));
                    ord_wdata = fpipe_reg;
                    w_next    = w_reg + NTW'(1);
                end
                if (k_reg == n_ext + KW'(1))
                begin
                    state_next = S_X_END;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end

            S_X_END:
            begin
                nt_we    = 1'b1;
                nt_wdata = w_reg;
                if (w_reg == '0)
                begin
                    valid_next[t_reg] = 1'b0;
                    total_next        = total_reg - IW'(1);
                end
                idx_next   = idx_reg + IW'(1);
                state_next = S_X_T;
            end

            S_G_ORD:
            begin
                state_next = S_G_SLOT;
            end

            S_G_SLOT:
            begin
                slot_re = 1'b1;
                if (k_reg == '0)
                begin
                    head_next = ord_rdata;
                end
                state_next = S_G_DATA;
            end

            S_G_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{status: ST_PEER, out_addr_hi: slot_rdata.addr_hi,
                                       out_addr_lo: slot_rdata.addr_lo,
                                       out_port: slot_rdata.port, peer_index: 3'(k_reg),
                                       last: (32'(k_reg) + 1 == 32'(cnt_reg))};
                    if (32'(k_reg) + 1 == 32'(cnt_reg))
                    begin
                        k_next     = '0;
                        state_next = (n_reg > NTW'(1)) ? S_R_RD : S_R_LAST;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        state_next = S_G_ORD;
                    end
                end
            end

            // rotate: shift the list up one place, head goes to the tail
            S_R_RD:
            begin
                ord_raddr  = slot_addr(t_reg, NW'(k_reg + KW'(1)));
                state_next = S_R_WR;
            end

            S_R_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = slot_addr(t_reg, NW'(k_reg));
                ord_wdata = ord_rdata;
                k_next    = k_reg + KW'(1);
                if (k_reg + KW'(2) < n_ext)
                begin
                    state_next = S_R_RD;
                end
                else
                begin
                    state_next = S_R_LAST;
                end
            end

            S_R_LAST:
            begin
                ord_we     = 1'b1;
                ord_waddr  = slot_addr(t_reg, NW'(n_reg - NTW'(1)));
                ord_wdata  = head_reg;
                state_next = S_IDLE;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{status: res_reg, out_addr_hi: 64'd0, out_addr_lo: 64'd0,
                                       out_port: 16'd0, peer_index: 3'd0, last: 1'b1};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/pat_ram.sv */
module pat_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16
    )
    (
        input  logic                                  clk,
        input  logic                                  we,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
        input  logic [WIDTH-1:0]                      wdata,
        input  logic                                  re,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
        output logic [WIDTH-1:0]                      rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
